[rtl/pie_pkg.sv]
// ============================================================================
// pie_pkg: shared constants and types for the power iteration eigen core
// Action codes, register indexes and the shared unit request/response.
// ============================================================================
package pie_pkg;

    localparam int MaxDim   = 8;

    // actions
    localparam logic [1:0] ACT_MAT    = 2'd0;
    localparam logic [1:0] ACT_VEC    = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;  // accepted, does nothing

    // configuration register indexes
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    // square root / divider request and response
    typedef struct packed {
        logic        sqrt_go;
        logic        div_go;
        logic [63:0] sq;
        logic [47:0] dividend_mag;
        logic [31:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
        logic [47:0] quot;
    } t_unit_rsp;

endpackage

[rtl/power_iteration_eigen_core.sv]
// ============================================================================
// power_iteration_eigen_core: dominant eigenvalue by power iteration
// Loads a Q16.16 matrix and start vector, then iterates y = A*b,
// norm = sqrt(sum y^2), b = y/norm until y settles or the limit is hit.
// ============================================================================
//
//  channel   ports                                   timing
//  -------   -------------------------------------   -------------------------
//  config    i_cfg_we, i_cfg_index, i_cfg_data       write at any edge, idle
//  command   i_start/o_busy, i_action..i_entry_value beat when start & !busy
//  result    o_valid, o_element_index..o_last        one beat per cycle
//
//  A load is a single beat. A pass of a run of n rows forms the products
//  (read, multiply, accumulate), the squares, the root, the serial
//  divisions (skipped when the norm is zero) and the compare; the run
//  ends with n output beats, and the divider takes most of its time.
//  Reset is synchronous active low; stores hold no reset value.
//  The receiver cannot stall: results stream out one per cycle.
//
module power_iteration_eigen_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_row_index,
    input  logic [2:0]  i_column_index,
    input  logic signed [31:0] i_entry_value,
    output logic        o_valid,
    output logic [2:0]  o_element_index,
    output logic signed [31:0] o_eigenvector_value,
    output logic [30:0] o_eigenvalue,
    output logic        o_converged,
    output logic [15:0] o_iteration_count,
    output logic        o_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MRD   = 4'd1;  // matrix read issued
    localparam logic [3:0] S_MUL   = 4'd2;  // multiply
    localparam logic [3:0] S_ACC   = 4'd3;  // accumulate
    localparam logic [3:0] S_SQ    = 4'd4;  // square sum
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_SQM   = 4'd10; // square registered

    // configuration
    logic [3:0]  r_size;
    logic [15:0] r_limit, r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 4'd2;
            r_limit <= 16'd1000;
            r_tol   <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pie_pkg::REG_SIZE:  r_size  <= i_cfg_data[3:0];
                pie_pkg::REG_LIMIT: r_limit <= i_cfg_data;
                pie_pkg::REG_TOL:   r_tol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stores
    logic signed [31:0] r_mat [0:63];
    logic signed [31:0] r_vec [0:7];
    logic signed [31:0] r_prod [0:7];
    logic signed [31:0] r_prev [0:7];
    logic signed [31:0] r_mdata;

    logic [3:0]  r_state;
    logic [2:0]  r_n1;          // n-1
    logic [2:0]  r_i, r_k;
    logic signed [63:0] r_mul;  // shared multiplier result
    logic signed [51:0] r_acc;
    logic [63:0] r_sq;
    logic [31:0] r_norm;
    logic        r_first, r_eq, r_conv;
    logic [15:0] r_iter;
    logic        r_neg;

    logic        accept;
    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    pie_pkg::t_unit_req unit_req;
    pie_pkg::t_unit_rsp unit_rsp;

    pie_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    // shared datapath helpers
    logic signed [51:0] acc_next;
    logic signed [47:0] floor_term;
    logic signed [31:0] yi;
    logic signed [32:0] diff;
    logic [32:0] adiff;
    logic [64:0] sq_sum;
    logic [47:0] ymag;
    logic [47:0] q;
    logic signed [31:0] bval;

    assign floor_term = r_mul[63:16];  // arithmetic shift = floor
    assign acc_next   = r_acc + 52'(floor_term);
    assign yi         = r_prod[r_i];
    assign diff       = 33'(yi) - 33'(r_prev[r_i]);
    assign adiff      = diff[32] ? 33'(-diff) : 33'(diff);
    assign sq_sum     = {1'b0, r_sq} + {1'b0, r_mul};
    // |y| scaled by 2^16 for the Q16.16 quotient
    assign ymag       = {(yi[31] ? 32'(-33'(yi)) : 32'(yi)), 16'd0};
    assign q          = unit_rsp.quot;

    always_comb begin
        if (q > 48'd2147483647)
            bval = r_neg ? 32'h80000000 : 32'h7FFFFFFF;
        else if (r_neg)
            bval = 32'(-$signed({1'b0, q[31:0]}));
        else
            bval = q[31:0];
        // saturate magnitude 2^31 on negative side is exact
        if (r_neg && q == 48'd2147483648) bval = 32'h80000000;
    end

    always_comb begin
        unit_req = '0;
        unit_req.sq           = r_sq;
        unit_req.dividend_mag = ymag;
        unit_req.divisor      = r_norm;
        unit_req.sqrt_go      = (r_state == S_SQRT) && (r_k == 3'd0);
        unit_req.div_go       = (r_state == S_DIV);
    end

    // matrix memory: write on load, registered read in run
    always_ff @(posedge i_clk) begin
        if (accept && i_action == pie_pkg::ACT_MAT)
            r_mat[{i_row_index, i_column_index}] <= i_entry_value;
        r_mdata <= r_mat[{r_i, r_k}];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b1;
            r_iter  <= '0;
            r_conv  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_action == pie_pkg::ACT_VEC)
                            r_vec[i_row_index] <= i_entry_value;
                        if (i_action == pie_pkg::ACT_RUN) begin
                            r_n1    <= (r_size == 4'd0) ? 3'd0 :
                                       (r_size > 4'd8) ? 3'd7 : 3'(r_size - 4'd1);
                            r_first <= 1'b1;
                            r_iter  <= '0;
                            r_conv  <= 1'b0;
                            r_norm  <= '0;
                            r_i     <= '0;
                            r_k     <= '0;
                            r_acc   <= '0;
                            if (r_limit == 16'd0) r_state <= S_OUT;
                            else                  r_state <= S_MRD;
                        end
                    end
                end
                S_MRD: r_state <= S_MUL;
                S_MUL: begin
                    r_mul   <= r_mdata * r_vec[r_k];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_k == r_n1) begin
                        r_acc  <= '0;
                        r_k    <= '0;
                        r_prod[r_i] <= (acc_next > 52'sd2147483647) ? 32'h7FFFFFFF :
                                       (acc_next < -52'sd2147483648) ? 32'h80000000 :
                                       acc_next[31:0];
                        if (r_i == r_n1) begin
                            r_i     <= '0;
                            r_sq    <= '0;
                            r_state <= S_SQ;
                        end else begin
                            r_i     <= r_i + 3'd1;
                            r_state <= S_MRD;
                        end
                    end else begin
                        r_acc   <= acc_next;
                        r_k     <= r_k + 3'd1;
                        r_state <= S_MRD;
                    end
                end
                S_SQ: begin
                    r_mul   <= yi * yi;
                    r_state <= S_SQM;
                end
                S_SQM: begin
                    r_sq <= sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
                    if (r_i == r_n1) begin
                        r_i     <= '0;
                        r_k     <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_i     <= r_i + 3'd1;
                        r_state <= S_SQ;
                    end
                end
                S_SQRT: begin
                    if (unit_rsp.done) begin
                        r_norm  <= unit_rsp.root;
                        r_k     <= '0;
                        r_state <= (unit_rsp.root == 32'd0) ? S_DWAIT : S_DIV;
                    end else begin
                        r_k <= 3'd1;
                    end
                end
                S_DIV: begin
                    r_neg   <= yi[31];
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (r_norm == 32'd0 || unit_rsp.done) begin
                        r_vec[r_i] <= (r_norm == 32'd0) ? 32'd0 : bval;
                        if (r_i == r_n1) begin
                            r_i     <= '0;
                            r_eq    <= 1'b1;
                            r_state <= S_CMP;
                        end else begin
                            r_i     <= r_i + 3'd1;
                            r_state <= (r_norm == 32'd0) ? S_DWAIT : S_DIV;
                        end
                    end
                end
                S_CMP: begin
                    if (adiff > 33'(r_tol)) r_eq <= 1'b0;
                    if (r_i == r_n1) begin
                        r_i <= '0;
                        if (!r_first && r_eq && !(adiff > 33'(r_tol))) begin
                            r_conv  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_first <= 1'b0;
                            r_iter  <= r_iter + 16'd1;
                            r_state <= (r_iter + 16'd1 >= r_limit) ? S_OUT : S_MRD;
                        end
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                S_OUT: begin
                    if (r_i == r_n1) begin
                        r_i     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // previous product copy during every compare
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP)
            r_prev[r_i] <= yi;
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_element_index     <= r_i;
            o_eigenvector_value <= r_vec[r_i];
            o_eigenvalue        <= r_norm[31] ? 31'h7FFFFFFF : r_norm[30:0];
            o_converged         <= r_conv;
            o_iteration_count   <= r_iter;
            o_last              <= (r_i == r_n1);
        end
    end

endmodule

[rtl/pie_sqdiv.sv]
// ============================================================================
// pie_sqdiv: shared bit-serial square root and unsigned divider
// Square root of a 64-bit value (2 bits per cycle), or a 48 by 32 bit
// restoring division (1 bit per cycle). One operation at a time.
// ============================================================================
module pie_sqdiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pie_pkg::t_unit_req  i_req,
    output pie_pkg::t_unit_rsp  o_rsp
);

    logic        r_busy, n_busy;
    logic        r_mode, n_mode;      // 0 sqrt, 1 divide
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_x, n_x;            // sqrt radicand / divide dividend shift
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_res, n_res;
    logic [47:0] r_quot, n_quot;
    logic [31:0] r_dvs, n_dvs;
    logic        r_done, n_done;

    logic [35:0] trial;
    logic [35:0] srem;
    logic [32:0] drem;

    // one step of the selected operation
    always_comb begin
        n_busy = r_busy;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_res  = r_res;
        n_quot = r_quot;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        srem   = {r_rem, r_x[63:62]};
        trial  = {2'b00, r_res, 2'b01};
        drem   = {r_rem[31:0], r_x[63]};
        if (!r_busy) begin
            if (i_req.sqrt_go) begin
                n_busy = 1'b1;
                n_mode = 1'b0;
                n_cnt  = 6'd32;
                n_x    = i_req.sq;
                n_rem  = '0;
                n_res  = '0;
            end else if (i_req.div_go) begin
                n_busy = 1'b1;
                n_mode = 1'b1;
                n_cnt  = 6'd48;
                n_x    = {i_req.dividend_mag, 16'd0};
                n_rem  = '0;
                n_quot = '0;
                n_dvs  = i_req.divisor;
            end
        end else begin
            if (!r_mode) begin
                n_x = {r_x[61:0], 2'b00};
                if (srem >= trial) begin
                    n_rem = 34'(srem - trial);
                    n_res = {r_res[30:0], 1'b1};
                end else begin
                    n_rem = 34'(srem);
                    n_res = {r_res[30:0], 1'b0};
                end
            end else begin
                n_x = {r_x[62:0], 1'b0};
                if (drem >= {1'b0, r_dvs}) begin
                    n_rem  = {1'b0, drem - {1'b0, r_dvs}};
                    n_quot = {r_quot[46:0], 1'b1};
                end else begin
                    n_rem  = {1'b0, drem};
                    n_quot = {r_quot[46:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res;
    assign o_rsp.quot = r_quot;

endmodule
